/* hdl/bucketed_hash_set_engine_top_assert.svh */
// Assertion macros for the bucketed hash set engine.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BUCKETED_HASH_SET_ENGINE_TOP_ASSERT_SVH
`define BUCKETED_HASH_SET_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BHS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bhs: assertion failed");
`define BHS_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("bhs: forbidden condition seen");
`else
`define BHS_ASSERT(lbl, clk, rstn, prop)
`define BHS_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

/* hdl/bhs_pkg.sv */
// Package of the bucketed hash set engine: field widths, parameter defaults,
// operation codes and the sequencer state type. Depends on nothing.
package bhs_pkg;

  localparam int MODE_W = 2;
  localparam int BIN_W  = 8;
  localparam int KEY_W  = 64;

  localparam int NUM_BINS_DEF          = 256;
  localparam int ENTRIES_PER_GROUP_DEF = 3;
  localparam int GROUPS_PER_BIN_DEF    = 4;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_REMOVE = MODE_W'(2);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CNT,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE,
    ST_RESP
  } state_e;

endpackage

/* hdl/bhs_in_if.sv */
// Input channel of the bucketed hash set engine: valid/ready plus the operation.
// Depends on bhs_pkg for the field widths.
interface bhs_in_if;
  logic                       valid;
  logic                       ready;
  logic [bhs_pkg::MODE_W-1:0] mode;
  logic [bhs_pkg::BIN_W-1:0]  bin;
  logic [bhs_pkg::KEY_W-1:0]  key;

  modport source (output valid, output mode, output bin, output key, input ready);
  modport sink   (input valid, input mode, input bin, input key, output ready);
endinterface

/* hdl/bhs_out_if.sv */
// Result channel of the bucketed hash set engine: valid/ready plus the status bits.
// Depends on nothing.
interface bhs_out_if;
  logic valid;
  logic ready;
  logic success;
  logic bin_full;

  modport source (output valid, output success, output bin_full, input ready);
  modport sink   (input valid, input success, input bin_full, output ready);
endinterface

/* hdl/bhs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bucketed_hash_set_engine_top.sv */
// Each transaction names a lookup, insert or remove of a 64-bit key in one bin and
// returns one result. After an item is accepted the engine reads the bin's count,
// then compares the stored keys against the item's key one entry per cycle through a
// single comparator fed by the key store's one read port. It compares at most
// ENTRIES_PER_GROUP * GROUPS_PER_BIN keys, twelve for a full bin; a successful remove
// then moves the bin's last key into the freed slot, and the result is held until it
// is taken. A transaction with the unused mode, or with a bin of NUM_BINS or more,
// goes straight to its result. Input ready is low while an item is in progress.
// After reset the engine zeroes the count memory of every usable bin (256 by default)
// before it accepts its first item.
// Depends on bhs_pkg, bhs_in_if, bhs_out_if, bhs_ram and the assertion header.
`include "bucketed_hash_set_engine_top_assert.svh"

module bucketed_hash_set_engine_top #(
  parameter int NUM_BINS          = bhs_pkg::NUM_BINS_DEF,
  parameter int ENTRIES_PER_GROUP = bhs_pkg::ENTRIES_PER_GROUP_DEF,
  parameter int GROUPS_PER_BIN    = bhs_pkg::GROUPS_PER_BIN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bhs_in_if.sink       in_i,
  bhs_out_if.source    out_o
);

  localparam int BIN_CAP  = ENTRIES_PER_GROUP * GROUPS_PER_BIN;
  localparam int NUM_USED = (NUM_BINS < 2 ** bhs_pkg::BIN_W) ? NUM_BINS : 2 ** bhs_pkg::BIN_W;
  localparam int KEY_DEPTH = NUM_USED * BIN_CAP;
  localparam int BIN_AW   = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;
  localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CNT_W    = $clog2(BIN_CAP + 1);
  localparam int IDX_W    = (BIN_CAP > 1) ? $clog2(BIN_CAP) : 1;

  bhs_pkg::state_e state_q, state_d;

  logic [BIN_AW-1:0]              clr_q, clr_d;
  logic [bhs_pkg::MODE_W-1:0]     mode_q, mode_d;
  logic [BIN_AW-1:0]              bin_q, bin_d;
  logic [bhs_pkg::KEY_W-1:0]      key_q, key_d;
  logic [KEY_AW-1:0]              base_q, base_d;
  logic [CNT_W-1:0]               n_q, n_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [IDX_W-1:0]               slot_q, slot_d;
  logic                           found_q, found_d;
  logic                           succ_q, succ_d;
  logic                           full_q, full_d;

  logic                           in_ready;
  logic                           out_valid;
  logic                           in_accept;
  logic                           op_ok;
  logic                           hit;
  logic                           scan_last;
  logic                           at_cap;
  logic                           clr_last;
  logic [BIN_AW-1:0]              in_bin_idx;
  logic [KEY_AW-1:0]              last_addr;

  logic                           cnt_we;
  logic [BIN_AW-1:0]              cnt_waddr;
  logic [CNT_W-1:0]               cnt_wdata;
  logic [BIN_AW-1:0]              cnt_raddr;
  logic [CNT_W-1:0]               cnt_rdata;

  logic                           key_we;
  logic [KEY_AW-1:0]              key_waddr;
  logic [bhs_pkg::KEY_W-1:0]      key_wdata;
  logic [KEY_AW-1:0]              key_raddr;
  logic [bhs_pkg::KEY_W-1:0]      key_rdata;

  bhs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_USED)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  bhs_ram #(
    .WIDTH (bhs_pkg::KEY_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  assign in_accept  = in_i.valid && in_ready;
  assign in_bin_idx = BIN_AW'(in_i.bin);
  assign op_ok      = (32'(in_i.bin) < NUM_BINS) &&
                      ((in_i.mode == bhs_pkg::MODE_LOOKUP) ||
                       (in_i.mode == bhs_pkg::MODE_INSERT) ||
                       (in_i.mode == bhs_pkg::MODE_REMOVE));

  // The shared comparator: one stored key against the item's key each cycle.
  assign hit       = (key_rdata == key_q);
  assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_q);
  assign at_cap    = (n_q == CNT_W'(BIN_CAP));
  assign clr_last  = (clr_q == BIN_AW'(NUM_USED - 1));
  assign last_addr = base_q + KEY_AW'(n_q) - KEY_AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bhs_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = bhs_pkg::ST_IDLE;
        end
      end
      bhs_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = op_ok ? bhs_pkg::ST_RD_CNT : bhs_pkg::ST_RESP;
        end
      end
      bhs_pkg::ST_RD_CNT: begin
        state_d = (cnt_rdata == '0) ? bhs_pkg::ST_DECIDE : bhs_pkg::ST_SCAN;
      end
      bhs_pkg::ST_SCAN: begin
        if (hit || scan_last) begin
          state_d = bhs_pkg::ST_DECIDE;
        end
      end
      bhs_pkg::ST_DECIDE: begin
        if ((mode_q == bhs_pkg::MODE_REMOVE) && found_q) begin
          state_d = bhs_pkg::ST_MOVE;
        end else begin
          state_d = bhs_pkg::ST_RESP;
        end
      end
      bhs_pkg::ST_MOVE: begin
        state_d = bhs_pkg::ST_RESP;
      end
      bhs_pkg::ST_RESP: begin
        if (out_o.ready) begin
          state_d = bhs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bhs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = bin_q;
    cnt_wdata = '0;
    cnt_raddr = in_bin_idx;
    key_we    = 1'b0;
    key_waddr = base_q + KEY_AW'(n_q);
    key_wdata = key_q;
    key_raddr = base_q;
    case (state_q)
      bhs_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
      end
      bhs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      bhs_pkg::ST_RD_CNT: begin
        key_raddr = base_q;
      end
      bhs_pkg::ST_SCAN: begin
        key_raddr = scan_last ? last_addr : (base_q + KEY_AW'(idx_q) + KEY_AW'(1));
      end
      bhs_pkg::ST_DECIDE: begin
        key_raddr = last_addr;
        if ((mode_q == bhs_pkg::MODE_INSERT) && !found_q && !at_cap) begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = n_q + CNT_W'(1);
        end
      end
      bhs_pkg::ST_MOVE: begin
        key_we    = 1'b1;
        key_waddr = base_q + KEY_AW'(slot_q);
        key_wdata = key_rdata;
        cnt_we    = 1'b1;
        cnt_wdata = n_q - CNT_W'(1);
      end
      bhs_pkg::ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_d   = clr_q;
    mode_d  = mode_q;
    bin_d   = bin_q;
    key_d   = key_q;
    base_d  = base_q;
    n_d     = n_q;
    idx_d   = idx_q;
    slot_d  = slot_q;
    found_d = found_q;
    succ_d  = succ_q;
    full_d  = full_q;
    case (state_q)
      bhs_pkg::ST_CLEAR: begin
        clr_d = clr_q + BIN_AW'(1);
      end
      bhs_pkg::ST_IDLE: begin
        if (in_accept) begin
          mode_d  = in_i.mode;
          bin_d   = in_bin_idx;
          key_d   = in_i.key;
          base_d  = KEY_AW'(in_bin_idx * BIN_CAP);
          found_d = 1'b0;
          succ_d  = 1'b0;
          full_d  = 1'b0;
        end
      end
      bhs_pkg::ST_RD_CNT: begin
        n_d   = cnt_rdata;
        idx_d = '0;
      end
      bhs_pkg::ST_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          slot_d  = idx_q;
        end else if (!scan_last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      bhs_pkg::ST_DECIDE: begin
        if (mode_q == bhs_pkg::MODE_LOOKUP) begin
          succ_d = found_q;
        end else if ((mode_q == bhs_pkg::MODE_INSERT) && !found_q) begin
          if (at_cap) begin
            full_d = 1'b1;
          end else begin
            succ_d = 1'b1;
          end
        end
      end
      bhs_pkg::ST_MOVE: begin
        succ_d = 1'b1;
      end
      default: begin
        succ_d = succ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhs_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    bin_q   <= bin_d;
    key_q   <= key_d;
    base_q  <= base_d;
    n_q     <= n_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    succ_q  <= succ_d;
    full_q  <= full_d;
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.success  = succ_q;
  assign out_o.bin_full = full_q;

  `BHS_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, out_o.valid && in_i.ready)
  `BHS_ASSERT(a_full_only_insert, clk_i, rst_ni,
              (out_o.valid && out_o.bin_full) |->
              ((mode_q == bhs_pkg::MODE_INSERT) && !out_o.success))
  `BHS_ASSERT(a_scan_count_ok, clk_i, rst_ni,
              (state_q == bhs_pkg::ST_SCAN) |-> ((n_q != '0) && (n_q <= CNT_W'(BIN_CAP))))
  `BHS_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready)

endmodule

/* tb/bucketed_hash_set_engine_top_test.sv */
// Self-checking testbench for the bucketed hash set engine: directed and random
// lookup, insert and remove transactions, checked against an in-bench shadow of every bin.
// Depends on bhs_pkg, bhs_in_if, bhs_out_if and bucketed_hash_set_engine_top.
module bucketed_hash_set_engine_top_test;

  localparam int MODE_W         = bhs_pkg::MODE_W;
  localparam int BIN_W          = bhs_pkg::BIN_W;
  localparam int KEY_W          = bhs_pkg::KEY_W;
  localparam int NUM_BINS_DEF   = bhs_pkg::NUM_BINS_DEF;
  localparam int BIN_CAP        = bhs_pkg::ENTRIES_PER_GROUP_DEF * bhs_pkg::GROUPS_PER_BIN_DEF;
  localparam int POOL_SIZE      = 24;
  localparam int HOT_BINS       = 3;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);

  typedef struct packed {
    logic success;
    logic bin_full;
  } set_status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bhs_in_if  in_if ();
  bhs_out_if out_if ();

  bucketed_hash_set_engine_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [KEY_W-1:0] shadow_keys  [NUM_BINS_DEF][BIN_CAP];
  int unsigned      shadow_count [NUM_BINS_DEF];
  set_status_t      pending_status [$];

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [BIN_W-1:0] hot_bin  [HOT_BINS];

  bit no_idle;
  int hold_req;
  int hold_seen;
  int hold_left;
  int stuck_cycles;
  int fail_count;
  int n_sent;
  int n_results;
  int n_success;
  int n_full;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", n_results, what);
    fail_count++;
  endtask

  function automatic set_status_t predict_set_op(input logic [MODE_W-1:0] mode,
                                                 input logic [BIN_W-1:0]  bin,
                                                 input logic [KEY_W-1:0]  key);
    set_status_t res;
    int          slot;
    int unsigned n;
    res  = '0;
    slot = -1;
    n    = shadow_count[bin];
    for (int i = 0; i < n; i++) begin
      if (slot < 0 && shadow_keys[bin][i] == key) slot = i;
    end
    case (mode)
      bhs_pkg::MODE_LOOKUP: begin
        res.success = (slot >= 0);
      end
      bhs_pkg::MODE_INSERT: begin
        if (slot < 0) begin
          if (n >= BIN_CAP) begin
            res.bin_full = 1'b1;
          end else begin
            shadow_keys[bin][n] = key;
            shadow_count[bin]   = n + 1;
            res.success         = 1'b1;
          end
        end
      end
      bhs_pkg::MODE_REMOVE: begin
        if (slot >= 0) begin
          shadow_keys[bin][slot] = shadow_keys[bin][n-1];
          shadow_count[bin]      = n - 1;
          res.success            = 1'b1;
        end
      end
      default: begin
      end
    endcase
    n_success += res.success;
    n_full    += res.bin_full;
    return res;
  endfunction

  // Called just after a rising edge; returns once the transaction has been accepted.
  task automatic offer_set_op(input logic [MODE_W-1:0] mode,
                              input logic [BIN_W-1:0]  bin,
                              input logic [KEY_W-1:0]  key);
    int gap;
    if (!no_idle && $urandom_range(99) < 6) begin
      gap = $urandom_range(4, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.bin   <= bin;
    in_if.key   <= key;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_status.push_back(predict_set_op(mode, bin, key));
    n_sent++;
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    stop_sending();
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    if ($urandom_range(99) < 65) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [BIN_W-1:0] random_bin();
    if ($urandom_range(99) < 75) return hot_bin[$urandom_range(HOT_BINS - 1)];
    return BIN_W'($urandom_range(NUM_BINS_DEF - 1));
  endfunction

  function automatic logic [MODE_W-1:0] random_mode(input int insert_pct,
                                                    input int remove_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return MODE_UNUSED;
    if (r < 3 + insert_pct) return bhs_pkg::MODE_INSERT;
    if (r < 3 + insert_pct + remove_pct) return bhs_pkg::MODE_REMOVE;
    return bhs_pkg::MODE_LOOKUP;
  endfunction

  function automatic logic [KEY_W-1:0] fill_key(input int i);
    if (i == 0) return '1;
    return {KEY_W{1'b0}} | (64'h1 << (i * 5 + 3)) | 64'(i);
  endfunction

  task automatic test_lookup_insert();
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'd0, '0);
    offer_set_op(bhs_pkg::MODE_INSERT, 8'd0, '0);
    offer_set_op(bhs_pkg::MODE_INSERT, 8'd0, '0);
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'd0, '0);
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'd0, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_full_bin();
    for (int i = 0; i < BIN_CAP; i++) offer_set_op(bhs_pkg::MODE_INSERT, 8'hFF, fill_key(i));
    offer_set_op(bhs_pkg::MODE_INSERT, 8'hFF, 64'h5A5A_A5A5_0F0F_F0F0);
    offer_set_op(bhs_pkg::MODE_INSERT, 8'hFF, fill_key(5));
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'hFF, 64'h5A5A_A5A5_0F0F_F0F0);
    offer_set_op(bhs_pkg::MODE_REMOVE, 8'hFF, fill_key(2));
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'hFF, fill_key(BIN_CAP - 1));
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'hFF, fill_key(2));
    offer_set_op(bhs_pkg::MODE_REMOVE, 8'hFF, fill_key(2));
    offer_set_op(bhs_pkg::MODE_INSERT, 8'hFF, 64'h5A5A_A5A5_0F0F_F0F0);
  endtask

  task automatic test_unused_mode();
    offer_set_op(MODE_UNUSED, 8'd0, '0);
    offer_set_op(bhs_pkg::MODE_LOOKUP, 8'd0, '0);
  endtask

  task automatic test_random_steady(input int count);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) offer_set_op(random_mode(50, 20), random_bin(), random_key());
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure(input int count);
    hold_req++;
    for (int i = 0; i < count; i++) offer_set_op(random_mode(35, 30), random_bin(), random_key());
  endtask

  task automatic test_drain_pause(input int count);
    for (int i = 0; i < count; i++) offer_set_op(random_mode(35, 30), random_bin(), random_key());
    wait_for_drain();
    @(posedge clk_i);
    for (int i = 0; i < count; i++) offer_set_op(random_mode(35, 30), random_bin(), random_key());
  endtask

  // Alternate insert-heavy and remove-heavy blocks so that hot bins swing
  // between empty and full.
  task automatic test_random_mixed(input int blocks, input int per_block);
    for (int b = 0; b < blocks; b++) begin
      for (int i = 0; i < per_block; i++) begin
        if (b % 2 == 0) offer_set_op(random_mode(60, 15), random_bin(), random_key());
        else offer_set_op(random_mode(15, 60), random_bin(), random_key());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst_ni !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    set_status_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      n_results++;
      if (pending_status.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_status.pop_front();
        if (out_if.success !== want.success) begin
          report_mismatch($sformatf("success %b, expected %b", out_if.success, want.success));
        end
        if (out_if.bin_full !== want.bin_full) begin
          report_mismatch($sformatf("bin_full %b, expected %b", out_if.bin_full,
                                    want.bin_full));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stuck_cycles, pending_status.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = bhs_pkg::MODE_LOOKUP;
    in_if.bin    = '0;
    in_if.key    = '0;
    for (int b = 0; b < NUM_BINS_DEF; b++) shadow_count[b] = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < HOT_BINS; i++) hot_bin[i] = BIN_W'($urandom_range(NUM_BINS_DEF - 1));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookup_insert();
    test_full_bin();
    test_unused_mode();
    test_random_steady(200);
    test_backpressure(20);
    test_drain_pause(10);
    test_random_mixed(9, 60);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions through lookup, insert and remove, %0d results checked.",
             n_sent, n_results);
    $display("%0d operations succeeded and %0d inserts hit a full bin.", n_success, n_full);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
